### rtl/unit_normal_from_three_points_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle normal unit
// Property helpers for the RTL file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef UNIT_NORMAL_FROM_THREE_POINTS_UNIT_MACROS_SVH
`define UNIT_NORMAL_FROM_THREE_POINTS_UNIT_MACROS_SVH

// assert that a condition implies another in the same cycle
`define UNF_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// assert that a condition implies another in the next cycle
`define UNF_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### rtl/unf_pkg.sv
// ----------------------------------------------------------------------------
// Triangle normal package
// Widths and defaults shared by the triangle normal unit.
// ----------------------------------------------------------------------------
`default_nettype none
package unf_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned OUT_BITS       = 16;
  localparam int unsigned NORM_BITS      = 31;
  localparam int unsigned FRAC_OUT       = 14;
  localparam int unsigned SQ_BITS        = 64;
  localparam int unsigned ROOT_BITS      = 32;
  // sqrt pipeline: root bits resolved per stage
  localparam int unsigned SQRT_PER_STAGE = 4;
  localparam int unsigned SQRT_STAGES    = ROOT_BITS / SQRT_PER_STAGE;
  // divider pipeline: quotient bits resolved per stage (quotient <= 2^14)
  localparam int unsigned QUO_BITS       = 15;
  localparam int unsigned DIV_PER_STAGE  = 3;
  localparam int unsigned DIV_STAGES     = QUO_BITS / DIV_PER_STAGE;
endpackage
`default_nettype wire

### rtl/unf_stream_if.sv
// ----------------------------------------------------------------------------
// Triangle normal stream interfaces
// Valid/ready channels for point triples and unit normals.
// ----------------------------------------------------------------------------
`default_nettype none
interface unf_point_if #(parameter int unsigned COORD_BITS = unf_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface unf_normal_if;
  logic                                valid;
  logic                                ready;
  logic signed [unf_pkg::OUT_BITS-1:0] normal_x, normal_y, normal_z;
  logic                                degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
                output ready);
endinterface
`default_nettype wire

### rtl/unit_normal_from_three_points_unit.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges, normalized to a Q2.14 unit vector.
// ----------------------------------------------------------------------------
// The unit takes one point triple A, B, C per cycle and returns, per triple,
// the unit normal of (C-A) x (B-A) in signed Q2.14, or a zero normal with
// degenerate set when the cross product is zero. It is a flat pipeline of 21
// register stages: edges, a multiply stage and a subtract stage for the cross
// product, two block normalization stages (bit length, then shift), squares,
// a sum, an 8-stage square root (4 root bits a stage), a 5-stage divider
// (3 quotient bits a stage, one lane per component, sharing the divisor),
// then an output register. Throughput is one request per cycle while the
// output is not stalled. The whole pipe advances together on a free output
// slot, so a stall holds every stage in place.
// Input ready is low while reset is asserted.
`default_nettype none
`include "unit_normal_from_three_points_unit_macros.svh"
module unit_normal_from_three_points_unit #(
  parameter int unsigned COORD_BITS = unf_pkg::COORD_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  unf_point_if.sink  pts,
  unf_normal_if.source nrm
);
  localparam int unsigned PRE   = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int unsigned EB    = COORD_BITS + 1 - PRE;   // edge width signed
  localparam int unsigned PB    = 2 * EB;                  // product width
  localparam int unsigned CB    = PB + 1;                  // cross width signed
  localparam int unsigned MB    = CB;                      // magnitude width
  localparam int unsigned NB    = unf_pkg::NORM_BITS;
  localparam int unsigned SQB   = unf_pkg::SQ_BITS;
  localparam int unsigned RB    = unf_pkg::ROOT_BITS;
  localparam int unsigned SQS   = unf_pkg::SQRT_STAGES;
  localparam int unsigned SPS   = unf_pkg::SQRT_PER_STAGE;
  localparam int unsigned QB    = unf_pkg::QUO_BITS;
  localparam int unsigned DS    = unf_pkg::DIV_STAGES;
  localparam int unsigned DPS   = unf_pkg::DIV_PER_STAGE;
  localparam int unsigned FO    = unf_pkg::FRAC_OUT;
  localparam int unsigned DNB   = NB + FO + 2;             // dividend width
  localparam int unsigned DDB   = RB + 1;                  // divisor width
  localparam int unsigned BLB   = $clog2(MB + 1);
  localparam int unsigned NST   = 7 + SQS + DS + 1;        // pipeline depth
  localparam int unsigned OB    = unf_pkg::OUT_BITS;

  // global advance: every stage moves when the output slot frees
  logic adv;
  logic [NST-1:0] vld;
  assign adv       = !vld[NST-1] || nrm.ready;
  assign pts.ready = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], pts.valid};
    end
  end

  // stage 0: edges, truncating toward zero when pre-scaled
  function automatic logic signed [EB-1:0] edge_d(logic signed [COORD_BITS-1:0] p,
                                                  logic signed [COORD_BITS-1:0] q);
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] t;
    d = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    t = (d < 0) ? -((-d) >>> PRE) : (d >>> PRE);
    return t[EB-1:0];
  endfunction

  logic signed [EB-1:0] r0 [3];
  logic signed [EB-1:0] u0 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      r0[0] <= edge_d(pts.c_x, pts.a_x);
      r0[1] <= edge_d(pts.c_y, pts.a_y);
      r0[2] <= edge_d(pts.c_z, pts.a_z);
      u0[0] <= edge_d(pts.b_x, pts.a_x);
      u0[1] <= edge_d(pts.b_y, pts.a_y);
      u0[2] <= edge_d(pts.b_z, pts.a_z);
    end
  end

  // stage 1: six products
  logic signed [PB-1:0] pp [6];
  always_ff @(posedge clk) begin
    if (adv) begin
      pp[0] <= r0[1] * u0[2];
      pp[1] <= r0[2] * u0[1];
      pp[2] <= r0[2] * u0[0];
      pp[3] <= r0[0] * u0[2];
      pp[4] <= r0[0] * u0[1];
      pp[5] <= r0[1] * u0[0];
    end
  end

  // stage 2: cross components, signs and magnitudes
  logic [MB-1:0] mg [3];
  logic [2:0]    sg2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [CB-1:0] c;
        c = {pp[2*i][PB-1], pp[2*i]} - {pp[2*i+1][PB-1], pp[2*i+1]};
        sg2[i] <= c[CB-1];
        mg[i]  <= c[CB-1] ? MB'(-c) : MB'(c);
      end
    end
  end

  // stage 3: bit length of the largest magnitude
  logic [MB-1:0]  mg3 [3];
  logic [2:0]     sg3;
  logic [BLB-1:0] bl3;
  logic           dg3;
  logic [MB-1:0]  orv;
  logic [BLB-1:0] bl_c;
  always_comb begin
    orv  = mg[0] | mg[1] | mg[2];
    bl_c = '0;
    for (int k = 0; k < MB; k++) if (orv[k]) bl_c = BLB'(k + 1);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mg3 <= mg;
      sg3 <= sg2;
      bl3 <= bl_c;
      dg3 <= (orv == '0);
    end
  end

  // stage 4: block normalization to 31 bits
  logic [NB-1:0] t4 [3];
  logic [2:0]    sg4;
  logic          dg4;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (32'(bl3) > NB) t4[i] <= NB'(mg3[i] >> (32'(bl3) - NB));
        else               t4[i] <= NB'({{(NB){1'b0}}, mg3[i]} << (NB - 32'(bl3)));
      end
      sg4 <= sg3;
      dg4 <= dg3;
    end
  end

  // stage 5: squares
  logic [2*NB-1:0] sq5 [3];
  logic [NB-1:0]   t5 [3];
  logic [2:0]      sg5;
  logic            dg5;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq5[i] <= t4[i] * t4[i];
      t5  <= t4;
      sg5 <= sg4;
      dg5 <= dg4;
    end
  end

  // stage 6: sum of squares
  logic [SQB-1:0] s6;
  logic [NB-1:0]  t6 [3];
  logic [2:0]     sg6;
  logic           dg6;
  always_ff @(posedge clk) begin
    if (adv) begin
      s6  <= SQB'(sq5[0]) + SQB'(sq5[1]) + SQB'(sq5[2]);
      t6  <= t5;
      sg6 <= sg5;
      dg6 <= dg5;
    end
  end

  // square root stages: digit-by-digit, SPS root bits per stage
  logic [SQB-1:0] sr_rem [SQS+1];
  logic [RB-1:0]  sr_rt  [SQS+1];
  logic [NB-1:0]  sr_t   [SQS+1][3];
  logic [2:0]     sr_sg  [SQS+1];
  logic           sr_dg  [SQS+1];
  assign sr_rem[0] = s6;
  assign sr_rt[0]  = '0;
  assign sr_t[0]   = t6;
  assign sr_sg[0]  = sg6;
  assign sr_dg[0]  = dg6;

  for (genvar g = 0; g < SQS; g++) begin : g_sqrt
    logic [SQB-1:0] rn;
    logic [RB-1:0]  qn;
    always_comb begin
      logic [SQB+1:0] trial;
      rn = sr_rem[g];
      qn = sr_rt[g];
      trial = '0;
      for (int k = 0; k < SPS; k++) begin
        // bit position of the root bit being tried
        trial = ({2'b00, SQB'(qn)} << (RB - (g*SPS + k))) |
                ((SQB+2)'(1) << (2*(RB - 1 - (g*SPS + k))));
        if ({2'b00, rn} >= trial) begin
          rn = rn - trial[SQB-1:0];
          qn[RB-1-(g*SPS+k)] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_rem[g+1] <= rn;
        sr_rt[g+1]  <= qn;
        sr_t[g+1]   <= sr_t[g];
        sr_sg[g+1]  <= sr_sg[g];
        sr_dg[g+1]  <= sr_dg[g];
      end
    end
  end

  // dividend t*2^15 + L, divisor 2L (L >= 2^30 when not degenerate)
  logic [DNB-1:0] dv_rem [DS+1][3];
  logic [QB-1:0]  dv_quo [DS+1][3];
  logic [DDB-1:0] dv_den [DS+1];
  logic [2:0]     dv_sg  [DS+1];
  logic           dv_dg  [DS+1];
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign dv_rem[0][i] = (DNB'(sr_t[SQS][i]) << (FO + 1)) + DNB'(sr_rt[SQS]);
    assign dv_quo[0][i] = '0;
  end
  assign dv_den[0] = {sr_rt[SQS], 1'b0};
  assign dv_sg[0]  = sr_sg[SQS];
  assign dv_dg[0]  = sr_dg[SQS];

  for (genvar g = 0; g < DS; g++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      unf_div #(
        .NBITS(DNB), .DBITS(DDB), .QBITS(QB), .STEP(DPS),
        .FIRST(QB - 1 - g*DPS)
      ) u_div (
        .clk(clk), .en(adv),
        .rem_in(dv_rem[g][i]), .den_in(dv_den[g]), .quo_in(dv_quo[g][i]),
        .rem(dv_rem[g+1][i]), .quo(dv_quo[g+1][i])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den[g+1] <= dv_den[g];
        dv_sg[g+1]  <= dv_sg[g];
        dv_dg[g+1]  <= dv_dg[g];
      end
    end
  end

  // output register: apply signs, zero on degenerate
  logic signed [OB-1:0] ox, oy, oz;
  logic                 odg;
  function automatic logic signed [OB-1:0] sgn(logic [QB-1:0] q, logic s, logic d);
    logic [OB-1:0] m;
    m = OB'(q);
    if (d) return '0;
    return s ? -m : m;
  endfunction
  always_ff @(posedge clk) begin
    if (adv) begin
      ox  <= sgn(dv_quo[DS][0], dv_sg[DS][0], dv_dg[DS]);
      oy  <= sgn(dv_quo[DS][1], dv_sg[DS][1], dv_dg[DS]);
      oz  <= sgn(dv_quo[DS][2], dv_sg[DS][2], dv_dg[DS]);
      odg <= dv_dg[DS];
    end
  end
  assign nrm.valid      = vld[NST-1];
  assign nrm.normal_x   = ox;
  assign nrm.normal_y   = oy;
  assign nrm.normal_z   = oz;
  assign nrm.degenerate = odg;

  // a stalled result holds
  `UNF_ASSERT_NEXT(a_hold, clk, rst, nrm.valid && !nrm.ready, nrm.valid && $stable(ox))
  // a degenerate result carries a zero normal
  `UNF_ASSERT_IMP(a_degz, clk, rst, nrm.valid && odg, ox == '0 && oy == '0 && oz == '0)
  // a stall blocks new requests
  `UNF_ASSERT_IMP(a_stall, clk, rst, nrm.valid && !nrm.ready, !pts.ready)
endmodule
`default_nettype wire

### rtl/unf_div.sv
// ----------------------------------------------------------------------------
// Triangle normal divider stage
// One pipeline step of the restoring divide q = num / den, several bits.
// ----------------------------------------------------------------------------
`default_nettype none
module unf_div #(
  parameter int unsigned NBITS = 48,
  parameter int unsigned DBITS = 33,
  parameter int unsigned QBITS = 15,
  parameter int unsigned STEP  = 3,
  parameter int unsigned FIRST = 14
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NBITS-1:0] rem_in,
  input  wire logic [DBITS-1:0] den_in,
  input  wire logic [QBITS-1:0] quo_in,
  output logic      [NBITS-1:0] rem,
  output logic      [QBITS-1:0] quo
);
  logic [NBITS-1:0] r_next;
  logic [QBITS-1:0] q_next;
  logic [NBITS+QBITS-1:0] trial;

  // resolve quotient bits FIRST down to FIRST-STEP+1
  always_comb begin
    r_next = rem_in;
    q_next = quo_in;
    trial  = '0;
    for (int k = 0; k < STEP; k++) begin
      trial = {{QBITS{1'b0}}, {(NBITS-DBITS){1'b0}}, den_in} << (FIRST - k);
      if ({{QBITS{1'b0}}, r_next} >= trial) begin
        r_next = r_next - trial[NBITS-1:0];
        q_next[FIRST-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= r_next;
      quo <= q_next;
    end
  end
endmodule
`default_nettype wire

### bench/tb_unit_normal_from_three_points_unit.sv
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Drives point triples through the valid/ready input, predicts each unit
// normal in an independent integer model and checks every returned normal in
// order, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_unit_normal_from_three_points_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = unf_pkg::COORD_BITS_DEF;
  localparam int LATENCY = 21;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t p [9];
  } triple_t;
  typedef struct {
    logic signed [unf_pkg::OUT_BITS-1:0] nx, ny, nz;
    logic                                degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  unf_point_if #(.COORD_BITS(CB)) pts ();
  unf_normal_if nrm ();

  unit_normal_from_three_points_unit #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst), .pts(pts.sink), .nrm(nrm.source)
  );

  normal_t normal_q [$];
  int      errors = 0;
  longint  cycles = 0;
  bit      long_hold = 1'b0;   // receiver holds off for a long stretch
  bit      rx_idle_on = 1'b1;  // random stalls on the receiver

  // Integer square root, bit by bit.
  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Cross product of the edges C-A and B-A, block normalized, then divided by length.
  function automatic normal_t unit_normal(triple_t t);
    normal_t         n;
    longint          rt [3], up [3], cr [3];
    longint unsigned mag [3], m, s, len, q;
    int              bl;
    for (int i = 0; i < 3; i++) begin
      rt[i] = longint'(t.p[6+i]) - longint'(t.p[i]);
      up[i] = longint'(t.p[3+i]) - longint'(t.p[i]);
    end
    cr[0] = rt[1] * up[2] - rt[2] * up[1];
    cr[1] = rt[2] * up[0] - rt[0] * up[2];
    cr[2] = rt[0] * up[1] - rt[1] * up[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? longint'(-cr[i]) : cr[i];
      if (mag[i] > m) m = mag[i];
    end
    n = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
    if (m == 0) return n;
    bl = 0;
    while (bl < 64 && (m >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl > unf_pkg::NORM_BITS) mag[i] >>= (bl - unf_pkg::NORM_BITS);
      else mag[i] <<= (unf_pkg::NORM_BITS - bl);
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << (unf_pkg::FRAC_OUT + 1)) + len) / (len * 2);
      if (cr[i] < 0) q = -q;
      case (i)
        0: n.nx = q[15:0];
        1: n.ny = q[15:0];
        default: n.nz = q[15:0];
      endcase
    end
    n.degen = 1'b0;
    return n;
  endfunction

  // Offer one request, hold it until accepted, then drop valid for a random gap, if any.
  task automatic send_triple(triple_t t);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    pts.valid <= 1'b1;
    pts.a_x <= t.p[0]; pts.a_y <= t.p[1]; pts.a_z <= t.p[2];
    pts.b_x <= t.p[3]; pts.b_y <= t.p[4]; pts.b_z <= t.p[5];
    pts.c_x <= t.p[6]; pts.c_y <= t.p[7]; pts.c_z <= t.p[8];
    do @(posedge clk); while (!pts.ready);
    normal_q.push_back(unit_normal(t));
    if (gap > 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(-(1 << (CB - 1)));
      1: return coord_t'((1 << (CB - 1)) - 1);
      2: return coord_t'(int'($urandom_range(0, 15)) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic triple_t rand_triple();
    triple_t t;
    for (int i = 0; i < 9; i++) t.p[i] = rand_coord();
    // collinear or repeated points now and then
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 3; i++) t.p[3+i] = t.p[i];
      1: for (int i = 0; i < 3; i++) t.p[6+i] = t.p[3+i];
      2: for (int i = 0; i < 3; i++)
           t.p[6+i] = coord_t'(t.p[i] + 2 * (t.p[3+i] - t.p[i]));
      default: ;
    endcase
    return t;
  endfunction

  function automatic triple_t mk(int ax, int ay, int az, int bx, int by, int bz,
                                 int cx, int cy, int cz);
    triple_t t;
    t.p = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
            coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz)};
    return t;
  endfunction

  // Axis-aligned, unit and extreme triangles, plus degenerate ones.
  task automatic test_directed();
    send_triple(mk(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
    send_triple(mk(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    send_triple(mk(0, 0, 0, 0, 0, 4096, 0, 4096, 0));
    send_triple(mk(0, 0, 0, 4096, 0, 0, 0, 0, 4096));
    send_triple(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triple(mk(0, 0, 0, 1, 1, 0, 1, 0, 1));
    send_triple(mk(5, 5, 5, 5, 5, 5, 5, 5, 5));
    send_triple(mk(0, 0, 0, 1, 2, 3, 2, 4, 6));
    send_triple(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                   -32768, 32767, -32768));
    send_triple(mk(-32768, -32768, -32768, -32768, 32767, 32767,
                   32767, -32768, 32767));
    send_triple(mk(32767, 32767, 32767, -32768, -32768, 32767,
                   32767, -32768, -32768));
    send_triple(mk(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767));
    send_triple(mk(-1, -1, -1, -1, -1, -1, 0, 0, 0));
    send_triple(mk(100, -200, 300, -400, 500, -600, 700, -800, 900));
    send_triple(mk(0, 0, 0, 3, 4, 0, 0, 0, 5));
    send_triple(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                   0, 0, 0));
  endtask

  task automatic test_random(int count);
    repeat (count) send_triple(rand_triple());
  endtask

  // Requests with random gaps while the receiver holds off, so the pipe fills.
  task automatic test_backpressure();
    long_hold = 1'b1;
    repeat (60) send_triple(rand_triple());
    long_hold = 1'b0;
  endtask

  // Output side: random ready, or a long hold counted here.
  initial begin
    int wait_n;
    nrm.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        nrm.ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_n = rx_idle_on ? $urandom_range(0, 6) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        nrm.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      nrm.ready <= 1'b1;
      do @(posedge clk); while (!nrm.valid);
    end
  end

  // Check each accepted normal against the oldest prediction.
  always @(posedge clk) begin
    normal_t e;
    if (!rst && nrm.valid && nrm.ready) begin
      if (normal_q.size() == 0) begin
        $error("normal returned with no request pending");
        errors++;
      end else begin
        e = normal_q.pop_front();
        if (nrm.normal_x !== e.nx) begin
          $error("normal_x expected %0d got %0d", e.nx, nrm.normal_x);
          errors++;
        end
        if (nrm.normal_y !== e.ny) begin
          $error("normal_y expected %0d got %0d", e.ny, nrm.normal_y);
          errors++;
        end
        if (nrm.normal_z !== e.nz) begin
          $error("normal_z expected %0d got %0d", e.nz, nrm.normal_z);
          errors++;
        end
        if (nrm.degenerate !== e.degen) begin
          $error("degenerate expected %0d got %0d", e.degen, nrm.degenerate);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    pts.valid = 1'b0;
    {pts.a_x, pts.a_y, pts.a_z, pts.b_x, pts.b_y, pts.b_z,
     pts.c_x, pts.c_y, pts.c_z} = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1000);
    rx_idle_on = 1'b0;
    test_random(400);
    rx_idle_on = 1'b1;
    test_random(540);
    pts.valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/unf_pkg.sv
rtl/unf_stream_if.sv
rtl/unf_div.sv
rtl/unit_normal_from_three_points_unit.sv
bench/tb_unit_normal_from_three_points_unit.sv
